// File: hdl/jbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jbt_pkg;

   // Fixed widths of the result fields
   localparam int FIELD_BITS = 24;

   // Token kinds
   localparam logic [3:0] KIND_NUMBER   = 4'd0;
   localparam logic [3:0] KIND_NULL     = 4'd1;
   localparam logic [3:0] KIND_FALSE    = 4'd2;
   localparam logic [3:0] KIND_TRUE     = 4'd3;
   localparam logic [3:0] KIND_IDENT    = 4'd4;
   localparam logic [3:0] KIND_COMMA    = 4'd5;
   localparam logic [3:0] KIND_COLON    = 4'd6;
   localparam logic [3:0] KIND_LBRACE   = 4'd7;
   localparam logic [3:0] KIND_RBRACE   = 4'd8;
   localparam logic [3:0] KIND_LBRACKET = 4'd9;
   localparam logic [3:0] KIND_RBRACKET = 4'd10;
   localparam logic [3:0] KIND_END      = 4'd11;
   localparam logic [3:0] KIND_ERROR    = 4'd12;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM     = 2'd1;
   localparam logic [1:0] ERR_NEWLINE    = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;

   // Keyword spellings, first character in the top byte
   localparam logic [39:0] KW_NULL_TEXT  = {"null", 8'h00};
   localparam logic [39:0] KW_FALSE_TEXT = "false";
   localparam logic [39:0] KW_TRUE_TEXT  = {"true", 8'h00};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [3:0]            token_kind;
      logic [FIELD_BITS-1:0] token_start;
      logic [FIELD_BITS-1:0] token_length;
      logic [1:0]            error_code;
      logic                  last_of_run;
   } rsp_item_type;

   // Up to three results pushed into the result queue in one cycle
   typedef struct packed {
      logic [1:0]                count;
      rsp_item_type [2:0]        data;
   } rsp_push_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic hit;
      case (c) inside
         ["0":"9"], ["a":"f"], ["A":"F"]: hit = 1'b1;
         default:                         hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      logic hit;
      case (c) inside
         ["a":"z"], ["A":"Z"]: hit = 1'b1;
         default:              hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Drop keyword candidates that do not take character c at position idx
   function automatic logic [2:0] keyword_step(input logic [2:0] mask,
                                               input logic       in_range,
                                               input logic [2:0] idx,
                                               input logic [7:0] c);
      logic [2:0]  next;
      logic [39:0] text;
      logic [39:0] shifted;
      logic [2:0]  len;
      next = mask;
      for (int k = 0; k < 3; k++) begin
         case (k)
            0:       begin text = KW_NULL_TEXT;  len = 3'd4; end
            1:       begin text = KW_FALSE_TEXT; len = 3'd5; end
            default: begin text = KW_TRUE_TEXT;  len = 3'd4; end
         endcase
         shifted = text << {idx, 3'b000};
         if (!in_range || idx >= len || shifted[39:32] != c) begin
            next[k] = 1'b0;
         end
      end
      return next;
   endfunction

   // Kind of a finished letter run
   function automatic logic [3:0] keyword_kind(input logic [2:0] mask,
                                               input logic       len_is4,
                                               input logic       len_is5);
      logic [3:0] kind;
      kind = KIND_IDENT;
      if (mask[0] && len_is4) kind = KIND_NULL;
      if (mask[1] && len_is5) kind = KIND_FALSE;
      if (mask[2] && len_is4) kind = KIND_TRUE;
      return kind;
   endfunction

endpackage

`default_nettype wire

// File: hdl/jbt_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface jbt_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hdl/jbt_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module jbt_rsp_queue
   import jbt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_push_type push,
   output logic              push_room,
   jbt_stream_if.source      rsp_if
);

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;
   localparam int CNT_W = 3;

   rsp_item_type     entry_ff [DEPTH];
   rsp_item_type     entry_in [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] tail;
   logic             pop;

   // Present the oldest entry
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.payload = entry_ff[head_ff];
   assign pop            = rsp_if.valid && rsp_if.ready;

   // Room for a worst-case transaction of three results
   assign push_room = (count_ff <= CNT_W'(DEPTH - 3));
   assign tail      = head_ff + count_ff[PTR_W-1:0];

   // Write pushed results behind the tail, advance head on pop
   always_comb begin
      entry_in = entry_ff;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.count) begin
            entry_in[tail + PTR_W'(i)] = push.data[i];
         end
      end
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/json_byte_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming JSON tokenizer. Document bytes arrive on req_if, one byte with
// its end_of_input flag per transaction; tokens leave on rsp_if with kind,
// start offset, length, error code and a flag on the last token a byte gave.
// Each accepted byte is lexed in the cycle it is taken, and its zero to
// three tokens are written into a four-entry result queue, which presents
// them on rsp_if in order.
// Throughput is one byte per cycle while bytes give at most one token each
// and the receiver keeps up. Input is taken only while the queue has room
// for three tokens, so a byte that gives two or three tokens, or a receiver
// that holds rsp_if.ready low, holds req_if.ready low until the queue drains
// back to one waiting entry. Nothing is lost or reordered under stalls.
// Reset empties the queue and starts a fresh document at offset zero; the
// block is ready as soon as reset is released. A NUL byte or end_of_input
// also starts a fresh document. Offsets and lengths count in OFFSET_BITS
// and saturate, then clip to the 24-bit result fields.
module json_byte_tokenizer_core
   import jbt_pkg::*;
#(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic    clock,
   input  wire logic    reset,
   jbt_stream_if.sink   req_if,
   jbt_stream_if.source rsp_if
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_NUMBER = 3'd1;
   localparam logic [2:0] MODE_WORD   = 3'd2;
   localparam logic [2:0] MODE_STRING = 3'd3;
   localparam logic [2:0] MODE_HALT   = 3'd4;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   // Lexer state
   logic [2:0] mode_ff, mode_in;
   logic       esc_ff, esc_in;
   offset_type pos_ff, pos_in;
   offset_type begin_ff, begin_in;
   offset_type wlen_ff, wlen_in;
   logic [2:0] mask_ff, mask_in;

   // Working values of one transaction
   logic [7:0]   c;
   logic         eoi;
   logic         accept;
   logic         push_room;
   offset_type   pos_inc;
   logic [2:0]   m;
   logic         e;
   offset_type   b;
   offset_type   w;
   logic [2:0]   k;
   logic         lex;
   logic         over;
   logic [3:0]   slot_v;
   logic [3:0]   slot_kind  [4];
   offset_type   slot_start [4];
   offset_type   slot_len   [4];
   logic [1:0]   slot_err   [4];
   logic [2:0]   n;
   rsp_push_type push;

   function automatic offset_type sat_inc(input offset_type v);
      return (&v) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [FIELD_BITS-1:0] clip_field(input offset_type v);
      logic [OFFSET_BITS+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, v};
      if (|wide[OFFSET_BITS+FIELD_BITS-1:FIELD_BITS]) return '1;
      return wide[FIELD_BITS-1:0];
   endfunction

   function automatic logic [3:0] run_kind(input logic [2:0] mode,
                                           input logic [2:0] mask,
                                           input offset_type len);
      if (mode == MODE_WORD) begin
         return keyword_kind(mask, len == OFFSET_BITS'(4), len == OFFSET_BITS'(5));
      end
      return KIND_NUMBER;
   endfunction

   assign c         = req_if.payload.in_byte;
   assign eoi       = req_if.payload.end_of_input;
   assign req_if.ready = push_room;
   assign accept    = req_if.valid && push_room;
   assign pos_inc   = sat_inc(pos_ff);

   // Lex one byte: run in progress, then between tokens, then end of input
   always_comb begin
      m      = mode_ff;
      e      = esc_ff;
      b      = begin_ff;
      w      = wlen_ff;
      k      = mask_ff;
      lex    = 1'b0;
      over   = 1'b0;
      slot_v = '0;
      for (int i = 0; i < 4; i++) begin
         slot_kind[i]  = KIND_END;
         slot_start[i] = '0;
         slot_len[i]   = '0;
         slot_err[i]   = ERR_NONE;
      end

      // Continue or close the current run
      case (mode_ff)
         MODE_HALT: begin
            if (c == CH_NUL) over = 1'b1;
         end
         MODE_STRING: begin
            if (c == CH_NUL) begin
               slot_v[0] = 1'b1; slot_kind[0] = KIND_ERROR;
               slot_start[0] = b; slot_len[0] = w; slot_err[0] = ERR_UNTERM;
               over = 1'b1;
            end else if (c == CH_LF) begin
               slot_v[0] = 1'b1; slot_kind[0] = KIND_ERROR;
               slot_start[0] = b; slot_len[0] = w; slot_err[0] = ERR_NEWLINE;
               m = MODE_HALT;
            end else if (c == CH_BSLASH) begin
               e = ~esc_ff;
               w = sat_inc(wlen_ff);
            end else if (c == CH_QUOTE && !esc_ff) begin
               slot_v[0] = 1'b1; slot_kind[0] = KIND_IDENT;
               slot_start[0] = b; slot_len[0] = w;
               m = MODE_IDLE;
            end else begin
               e = 1'b0;
               w = sat_inc(wlen_ff);
            end
         end
         MODE_NUMBER, MODE_WORD: begin
            if (mode_ff == MODE_NUMBER &&
                (is_hex(c) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS)) begin
               w = sat_inc(wlen_ff);
            end else if (mode_ff == MODE_WORD && is_alpha(c)) begin
               k = keyword_step(mask_ff, wlen_ff[OFFSET_BITS-1:3] == '0,
                                wlen_ff[2:0], c);
               w = sat_inc(wlen_ff);
            end else begin
               slot_v[0] = 1'b1; slot_kind[0] = run_kind(mode_ff, mask_ff, wlen_ff);
               slot_start[0] = b; slot_len[0] = w;
               m = MODE_IDLE;
               lex = 1'b1;
            end
         end
         default: begin
            m   = MODE_IDLE;
            lex = 1'b1;
         end
      endcase

      // Start a token from a byte between tokens
      if (lex) begin
         slot_start[1] = pos_ff;
         slot_len[1]   = OFFSET_BITS'(1);
         case (c) inside
            CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
            end
            CH_NUL: begin
               slot_v[1] = 1'b1; slot_kind[1] = KIND_END;
               slot_len[1] = '0;
               over = 1'b1;
            end
            CH_QUOTE: begin
               m = MODE_STRING;
               b = pos_inc;
               w = '0;
               e = 1'b0;
            end
            CH_COMMA:    begin slot_v[1] = 1'b1; slot_kind[1] = KIND_COMMA;    end
            CH_COLON:    begin slot_v[1] = 1'b1; slot_kind[1] = KIND_COLON;    end
            CH_LBRACE:   begin slot_v[1] = 1'b1; slot_kind[1] = KIND_LBRACE;   end
            CH_RBRACE:   begin slot_v[1] = 1'b1; slot_kind[1] = KIND_RBRACE;   end
            CH_LBRACKET: begin slot_v[1] = 1'b1; slot_kind[1] = KIND_LBRACKET; end
            CH_RBRACKET: begin slot_v[1] = 1'b1; slot_kind[1] = KIND_RBRACKET; end
            CH_MINUS, CH_PLUS, ["0":"9"]: begin
               m = MODE_NUMBER;
               b = pos_ff;
               w = OFFSET_BITS'(1);
            end
            ["a":"z"], ["A":"Z"]: begin
               m = MODE_WORD;
               b = pos_ff;
               w = OFFSET_BITS'(1);
               k = keyword_step(3'b111, 1'b1, 3'd0, c);
            end
            default: begin
               slot_v[1] = 1'b1; slot_kind[1] = KIND_ERROR;
               slot_err[1] = ERR_UNEXPECTED;
               m = MODE_HALT;
            end
         endcase
      end

      // Close the document on end of input
      if (!over && eoi) begin
         if (m == MODE_NUMBER || m == MODE_WORD) begin
            slot_v[2] = 1'b1; slot_kind[2] = run_kind(m, k, w);
            slot_start[2] = b; slot_len[2] = w;
         end
         if (m == MODE_NUMBER || m == MODE_WORD || m == MODE_IDLE) begin
            slot_v[3] = 1'b1; slot_kind[3] = KIND_END;
            slot_start[3] = pos_inc; slot_len[3] = '0;
         end else if (m == MODE_STRING) begin
            slot_v[3] = 1'b1; slot_kind[3] = KIND_ERROR;
            slot_start[3] = b; slot_len[3] = w; slot_err[3] = ERR_UNTERM;
         end
         over = 1'b1;
      end
   end

   // Pack the produced tokens in order and mark the last one
   always_comb begin
      push = '0;
      n    = '0;
      for (int i = 0; i < 4; i++) begin
         if (accept && slot_v[i] && n < 3'd3) begin
            push.data[n[1:0]].token_kind   = slot_kind[i];
            push.data[n[1:0]].token_start  = clip_field(slot_start[i]);
            push.data[n[1:0]].token_length = clip_field(slot_len[i]);
            push.data[n[1:0]].error_code   = slot_err[i];
            n = n + 3'd1;
         end
      end
      if (n != '0) push.data[2'(n - 3'd1)].last_of_run = 1'b1;
      push.count = n[1:0];
   end

   // Advance the lexer state, or start a fresh document
   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      wlen_in  = wlen_ff;
      mask_in  = mask_ff;
      if (accept) begin
         if (over) begin
            mode_in  = MODE_IDLE;
            esc_in   = 1'b0;
            pos_in   = '0;
            begin_in = '0;
            wlen_in  = '0;
            mask_in  = 3'b111;
         end else begin
            mode_in  = m;
            esc_in   = e;
            pos_in   = pos_inc;
            begin_in = b;
            wlen_in  = w;
            mask_in  = k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
         begin_ff <= '0;
         wlen_ff  <= '0;
         mask_ff  <= 3'b111;
      end else begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         wlen_ff  <= wlen_in;
         mask_ff  <= mask_in;
      end
   end

   jbt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_room (push_room),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

// File: verif/jbt_token_checker.sv
`timescale 1ns / 1ps

// Watches the byte and token channels, predicts the tokens of every accepted
// byte and compares each token transaction with the oldest prediction.
module jbt_token_checker
   import jbt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_ready,
   input  req_item_type req_payload,
   input  wire logic   rsp_valid,
   input  wire logic   rsp_ready,
   input  rsp_item_type rsp_payload,
   output int          fail_count,
   output int          pending_count,
   output int          token_count,
   output int          error_token_count
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_WORD,
      MODE_STRING,
      MODE_HALT
   } lex_mode_type;

   localparam logic [FIELD_BITS-1:0] OFFSET_MAX = '1;

   // Lexer state as the block should hold it
   lex_mode_type          lex_mode;
   logic                  escape_open;
   logic [FIELD_BITS-1:0] byte_offset;
   logic [FIELD_BITS-1:0] content_start;
   logic [FIELD_BITS-1:0] run_length;
   logic [2:0]            keyword_alive;

   string        keyword_text [3] = '{"null", "false", "true"};
   rsp_item_type byte_tokens[$];
   rsp_item_type predicted_tokens[$];

   function automatic logic [FIELD_BITS-1:0] sat_inc(input logic [FIELD_BITS-1:0] v);
      return (v == OFFSET_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void fresh_document();
      lex_mode      = MODE_IDLE;
      escape_open   = 1'b0;
      byte_offset   = '0;
      content_start = '0;
      run_length    = '0;
      keyword_alive = 3'b111;
   endfunction

   // Queue a token for this byte; a byte never gives more than three
   function automatic void emit(input logic [3:0] kind, input logic [FIELD_BITS-1:0] start,
                                input logic [FIELD_BITS-1:0] len, input logic [1:0] err);
      rsp_item_type t;
      if (byte_tokens.size() >= 3) return;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.error_code   = err;
      t.last_of_run  = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // Drop keywords that cannot take this letter at the current position
   function automatic void extend_word(input logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
         if (run_length >= keyword_text[k].len() || keyword_text[k][run_length] != c) begin
            keyword_alive[k] = 1'b0;
         end
      end
      run_length = sat_inc(run_length);
   endfunction

   // Close a pending number or letter run
   function automatic void close_run();
      logic [3:0] kind;
      kind = KIND_NUMBER;
      if (lex_mode == MODE_WORD) begin
         kind = KIND_IDENT;
         if (keyword_alive[0] && run_length == 4) kind = KIND_NULL;
         if (keyword_alive[1] && run_length == 5) kind = KIND_FALSE;
         if (keyword_alive[2] && run_length == 4) kind = KIND_TRUE;
      end
      emit(kind, content_start, run_length, ERR_NONE);
      lex_mode = MODE_IDLE;
   endfunction

   // Lex a byte that falls between tokens; return 1 if it ends the document
   function automatic logic lex_between(input logic [7:0] c, input logic [FIELD_BITS-1:0] pos);
      logic [3:0] kind;
      logic       single;
      single = 1'b1;
      kind   = KIND_COMMA;
      case (c)
         CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b0;
         CH_NUL: begin
            emit(KIND_END, pos, '0, ERR_NONE);
            return 1'b1;
         end
         CH_QUOTE: begin
            lex_mode      = MODE_STRING;
            content_start = sat_inc(pos);
            run_length    = '0;
            escape_open   = 1'b0;
            return 1'b0;
         end
         CH_COMMA:    kind = KIND_COMMA;
         CH_COLON:    kind = KIND_COLON;
         CH_LBRACE:   kind = KIND_LBRACE;
         CH_RBRACE:   kind = KIND_RBRACE;
         CH_LBRACKET: kind = KIND_LBRACKET;
         CH_RBRACKET: kind = KIND_RBRACKET;
         default: begin
            single = 1'b0;
            if (c == CH_MINUS || c == CH_PLUS || (c >= "0" && c <= "9")) begin
               lex_mode      = MODE_NUMBER;
               content_start = pos;
               run_length    = FIELD_BITS'(1);
            end else if (is_letter(c)) begin
               lex_mode      = MODE_WORD;
               content_start = pos;
               run_length    = '0;
               keyword_alive = 3'b111;
               extend_word(c);
            end else begin
               emit(KIND_ERROR, pos, FIELD_BITS'(1), ERR_UNEXPECTED);
               lex_mode = MODE_HALT;
            end
         end
      endcase
      if (single) emit(kind, pos, FIELD_BITS'(1), ERR_NONE);
      return 1'b0;
   endfunction

   // Work out the tokens of one accepted byte and append them to the predictions
   function automatic void tokenize_byte(input logic [7:0] c, input logic eoi);
      logic [FIELD_BITS-1:0] pos;
      logic                  done;
      logic                  relex;
      rsp_item_type          t;
      pos   = byte_offset;
      done  = 1'b0;
      relex = 1'b0;
      byte_tokens.delete();
      case (lex_mode)
         MODE_HALT: begin
            if (eoi || c == CH_NUL) fresh_document();
            else byte_offset = sat_inc(pos);
            return;
         end
         MODE_STRING: begin
            if (c == CH_NUL) begin
               emit(KIND_ERROR, content_start, run_length, ERR_UNTERM);
               done = 1'b1;
            end else if (c == CH_LF) begin
               emit(KIND_ERROR, content_start, run_length, ERR_NEWLINE);
               lex_mode = MODE_HALT;
            end else if (c == CH_BSLASH) begin
               escape_open = ~escape_open;
               run_length  = sat_inc(run_length);
            end else if (c == CH_QUOTE && !escape_open) begin
               emit(KIND_IDENT, content_start, run_length, ERR_NONE);
               lex_mode = MODE_IDLE;
            end else begin
               escape_open = 1'b0;
               run_length  = sat_inc(run_length);
            end
         end
         MODE_NUMBER: begin
            if ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
                c == CH_DOT || c == CH_MINUS || c == CH_PLUS) begin
               run_length = sat_inc(run_length);
            end else begin
               close_run();
               relex = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_letter(c)) begin
               extend_word(c);
            end else begin
               close_run();
               relex = 1'b1;
            end
         end
         default: relex = 1'b1;
      endcase

      if (relex) done = lex_between(c, pos);

      // End of input on an ordinary byte closes whatever is still open
      if (!done && eoi) begin
         if (lex_mode == MODE_NUMBER || lex_mode == MODE_WORD) close_run();
         if (lex_mode == MODE_IDLE) emit(KIND_END, sat_inc(pos), '0, ERR_NONE);
         else if (lex_mode == MODE_STRING)
            emit(KIND_ERROR, content_start, run_length, ERR_UNTERM);
         done = 1'b1;
      end

      if (done) fresh_document();
      else byte_offset = sat_inc(pos);

      foreach (byte_tokens[i]) begin
         t = byte_tokens[i];
         t.last_of_run = (i == byte_tokens.size() - 1);
         predicted_tokens.push_back(t);
      end
   endfunction

   // Compare token transactions first, then predict from the byte transaction
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         fresh_document();
         predicted_tokens.delete();
         fail_count        = 0;
         token_count       = 0;
         error_token_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_tokens.size() == 0) begin
               $error("unexpected token: kind %0d start %0d length %0d",
                      rsp_payload.token_kind, rsp_payload.token_start,
                      rsp_payload.token_length);
               fail_count++;
            end else begin
               want = predicted_tokens.pop_front();
               token_count++;
               if (want.token_kind == KIND_ERROR) error_token_count++;
               if (rsp_payload.token_kind !== want.token_kind) begin
                  $error("token_kind: expected %0d, actual %0d",
                         want.token_kind, rsp_payload.token_kind);
                  fail_count++;
               end
               if (rsp_payload.token_start !== want.token_start) begin
                  $error("token_start: expected %0d, actual %0d",
                         want.token_start, rsp_payload.token_start);
                  fail_count++;
               end
               if (rsp_payload.token_length !== want.token_length) begin
                  $error("token_length: expected %0d, actual %0d",
                         want.token_length, rsp_payload.token_length);
                  fail_count++;
               end
               if (rsp_payload.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, actual %0d",
                         want.error_code, rsp_payload.error_code);
                  fail_count++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, rsp_payload.last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            tokenize_byte(req_payload.in_byte, req_payload.end_of_input);
         end
      end
      pending_count = predicted_tokens.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import jbt_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_STALL   = 300;
   localparam int RANDOM_BYTES = 420;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   token_count;
   int   error_token_count;
   int   byte_count;
   int   cycle_count;
   int   document_count;
   bit   flow_gaps;
   bit   long_stall_pending;
   logic [7:0] doc_bytes[$];

   jbt_stream_if #(.payload_type(req_item_type)) req_if ();
   jbt_stream_if #(.payload_type(rsp_item_type)) rsp_if ();

   json_byte_tokenizer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   jbt_token_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_payload       (req_if.payload),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_payload       (rsp_if.payload),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .token_count       (token_count),
      .error_token_count (error_token_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Give up after a generous number of cycles
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_char(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // Token receiver: random stalls, plus one long hold-off when asked
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else if (flow_gaps && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_length() - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Offer one byte and hold it until the transaction completes
   task automatic send_byte(input logic [7:0] c, input logic eoi);
      int gap;
      gap = (flow_gaps && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= {c, eoi};
      do @(posedge clock); while (!req_if.ready);
      byte_count++;
   endtask

   // Send the buffered document, ending it by end_of_input or by a NUL byte
   task automatic send_doc(input bit end_by_flag);
      if (!end_by_flag) doc_bytes.push_back(CH_NUL);
      foreach (doc_bytes[i]) send_byte(doc_bytes[i], end_by_flag && i == doc_bytes.size() - 1);
      doc_bytes.delete();
      document_count++;
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) doc_bytes.push_back(s[i]);
   endtask

   // Hold the sender until every predicted token has come out
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Build a mostly well-formed document with random content
   task automatic build_document();
      string kw [3] = '{"null", "false", "true"};
      string word;
      int    variant;
      repeat ($urandom_range(1, 10)) begin
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 2)) doc_bytes.push_back(pick_char(" \t\r\n"));
         end
         case ($urandom_range(0, 5))
            0: doc_bytes.push_back(pick_char("{}[],:"));
            1: begin
               doc_bytes.push_back(pick_char("+-0123456789"));
               repeat ($urandom_range(0, 5))
                  doc_bytes.push_back(pick_char("0123456789abcdefABCDEF.+-"));
            end
            2: begin
               // keywords, with near misses either side
               word    = kw[$urandom_range(0, 2)];
               variant = $urandom_range(0, 3);
               if (variant == 0) word = word.substr(0, word.len() - 2);
               push_text(word);
               if (variant == 1) doc_bytes.push_back(pick_char("aelnrstuxZ"));
            end
            3: begin
               repeat ($urandom_range(1, 6))
                  doc_bytes.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
            end
            default: begin
               doc_bytes.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     doc_bytes.push_back(CH_BSLASH);
                     doc_bytes.push_back(pick_char("\"\\/bnrtu\n"));
                  end else begin
                     doc_bytes.push_back(pick_char("aZ09 {}:,#~"));
                     if ($urandom_range(0, 2) == 0)
                        doc_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
                  end
               end
               if ($urandom_range(0, 15) != 0) doc_bytes.push_back(CH_QUOTE);
            end
         endcase
      end
   endtask

   initial begin
      int target;
      req_if.valid       = 1'b0;
      req_if.payload     = '0;
      reset              = 1'b1;
      flow_gaps          = 1'b0;
      long_stall_pending = 1'b0;
      byte_count         = 0;
      document_count     = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all kinds but true, escaped quote, runs closed by next byte
      flow_gaps = 1'b1;
      push_text("[{\"\\\"\":null,+.9}]");
      send_doc(1'b1);
      // end of input inside a string
      push_text("\"x");
      send_doc(1'b1);
      // newline in a string, then bytes ignored until NUL
      push_text("\"\n");
      doc_bytes.push_back(8'hFF);
      send_doc(1'b0);
      // unexpected character, then ignored up to end of input
      doc_bytes.push_back(8'hFF);
      push_text("a");
      send_doc(1'b1);
      // bare NUL gives an end token at offset zero
      send_doc(1'b0);
      // keyword closed by end of input
      push_text("false");
      send_doc(1'b1);
      // NUL inside a string
      push_text("\"ab");
      send_doc(1'b0);
      settle();

      // Random documents, with a long receiver hold-off and sender drains
      target = byte_count + RANDOM_BYTES;
      while (byte_count < target) begin
         flow_gaps = ($urandom_range(0, 3) != 0);
         if (document_count == 12 || document_count == 45) begin
            flow_gaps          = 1'b0;
            long_stall_pending = 1'b1;
         end
         if (document_count % 15 == 7) settle();
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 12)) doc_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_document();
         end
         send_doc(1'($urandom_range(0, 1)));
      end

      settle();
      repeat (10) @(negedge clock);
      $display("tb: %0d bytes in %0d documents, %0d tokens checked (%0d error tokens), %0d cycles",
               byte_count, document_count, token_count, error_token_count, cycle_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
